// ===== src/superio_gpio_config_port_defines.svh =====
// Assertion macros shared by the configuration port checker.
`ifndef SUPERIO_GPIO_CONFIG_PORT_DEFINES_SVH
`define SUPERIO_GPIO_CONFIG_PORT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SGCP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SGCP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define SGCP_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/sgcp_pkg.sv =====
// Package with the beat types and register codes of the configuration port.
`default_nettype none
package sgcp_pkg;

    typedef struct packed {
        logic        operation;
        logic [15:0] io_address;
        logic [7:0]  write_data;
        logic [7:0]  bank0_pin_levels;
        logic [7:0]  bank1_pin_levels;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       address_hit;
        logic       unlocked_flag;
        logic [7:0] bank0_drive_enable;
        logic [7:0] bank0_drive_level;
        logic [7:0] bank1_drive_enable;
        logic [7:0] bank1_drive_level;
    } out_beat_t;

    // Configuration register indexes.
    localparam logic CFG_PORT_BASE = 1'b0;
    localparam logic CFG_CHIP_ID   = 1'b1;

    localparam logic OP_WRITE = 1'b1;

    localparam logic [7:0] KEY_UNLOCK = 8'h87;
    localparam logic [7:0] KEY_LOCK   = 8'hAA;

    localparam logic [7:0] REG_LDSEL  = 8'h07;
    localparam logic [7:0] REG_ID_HI  = 8'h20;
    localparam logic [7:0] REG_ID_LO  = 8'h21;
    localparam logic [7:0] REG_ENABLE = 8'h30;
    localparam logic [7:0] REG_DIR0   = 8'hE0;
    localparam logic [7:0] REG_DATA0  = 8'hE1;
    localparam logic [7:0] REG_DIR1   = 8'hE4;
    localparam logic [7:0] REG_DATA1  = 8'hE5;
    localparam logic [7:0] REG_MODE0  = 8'hE0;
    localparam logic [7:0] REG_MODE1  = 8'hE1;

    localparam logic [7:0] DEV_GPIO = 8'h07;
    localparam logic [7:0] DEV_MODE = 8'h0F;

    typedef enum logic [2:0] {
        ST_LOCKED   = 3'b001,
        ST_KEY_SEEN = 3'b010,
        ST_OPEN     = 3'b100
    } unlock_state_t;

endpackage
`default_nettype wire

// ===== src/sgcp_core.sv =====
// Register file, key sequence and access decode of the configuration port.
`default_nettype none
module sgcp_core #(
    parameter int PINS_PER_BANK = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             step_en,
    input  wire sgcp_pkg::in_beat_t beat,
    input  wire logic [15:0]      port_base,
    input  wire logic [15:0]      chip_id,
    output sgcp_pkg::out_beat_t   result
);
    import sgcp_pkg::*;

    localparam logic [7:0] PinMask = 8'((16'd1 << PINS_PER_BANK) - 16'd1);

    unlock_state_t stage_reg, stage_next;
    logic [7:0] index_reg, index_next;
    logic [7:0] device_reg, device_next;
    logic [7:0] enable_reg, enable_next;
    logic [7:0] dir0_reg, dir0_next;
    logic [7:0] latch0_reg, latch0_next;
    logic [7:0] dir1_reg, dir1_next;
    logic [7:0] latch1_reg, latch1_next;
    logic [7:0] mode0_reg, mode0_next;
    logic [7:0] mode1_reg, mode1_next;

    logic       is_write;
    logic       at_index;
    logic       at_data;
    logic       is_open;
    logic [7:0] reg_value;
    logic [7:0] rd_data;

    assign is_write = beat.operation == OP_WRITE;
    assign at_index = beat.io_address == port_base;
    assign at_data  = beat.io_address == 16'(port_base + 16'd1);
    assign is_open  = stage_reg == ST_OPEN;

    // Value of the indexed register for a data port read.
    always_comb begin
        reg_value = 8'h00;
        if (index_reg == REG_LDSEL) begin
            reg_value = device_reg;
        end else if (index_reg == REG_ID_HI) begin
            reg_value = chip_id[15:8];
        end else if (index_reg == REG_ID_LO) begin
            reg_value = chip_id[7:0];
        end else if (device_reg == DEV_GPIO) begin
            if (index_reg == REG_ENABLE) begin
                reg_value = enable_reg;
            end else if (index_reg == REG_DIR0) begin
                reg_value = dir0_reg;
            end else if (index_reg == REG_DATA0) begin
                reg_value = ((beat.bank0_pin_levels & dir0_reg) | (latch0_reg & ~dir0_reg))
                            & PinMask;
            end else if (index_reg == REG_DIR1) begin
                reg_value = dir1_reg;
            end else if (index_reg == REG_DATA1) begin
                reg_value = ((beat.bank1_pin_levels & dir1_reg) | (latch1_reg & ~dir1_reg))
                            & PinMask;
            end
        end else if (device_reg == DEV_MODE) begin
            if (index_reg == REG_MODE0) begin
                reg_value = mode0_reg;
            end else if (index_reg == REG_MODE1) begin
                reg_value = mode1_reg;
            end
        end
    end

    always_comb begin
        stage_next  = stage_reg;
        index_next  = index_reg;
        device_next = device_reg;
        enable_next = enable_reg;
        dir0_next   = dir0_reg;
        latch0_next = latch0_reg;
        dir1_next   = dir1_reg;
        latch1_next = latch1_reg;
        mode0_next  = mode0_reg;
        mode1_next  = mode1_reg;
        rd_data     = is_write ? 8'h00 : 8'hFF;

        if (is_write) begin
            if (at_index) begin
                if (is_open) begin
                    if (beat.write_data == KEY_LOCK) begin
                        stage_next = ST_LOCKED;
                    end else begin
                        index_next = beat.write_data;
                    end
                end else if (beat.write_data == KEY_UNLOCK) begin
                    stage_next = (stage_reg == ST_KEY_SEEN) ? ST_OPEN : ST_KEY_SEEN;
                end else begin
                    stage_next = ST_LOCKED;
                end
            end else if (at_data && is_open) begin
                if (index_reg == REG_LDSEL) begin
                    device_next = beat.write_data;
                end else if (device_reg == DEV_GPIO) begin
                    if (index_reg == REG_ENABLE) begin
                        enable_next = beat.write_data;
                    end else if (index_reg == REG_DIR0) begin
                        dir0_next = beat.write_data;
                    end else if (index_reg == REG_DATA0) begin
                        latch0_next = beat.write_data;
                    end else if (index_reg == REG_DIR1) begin
                        dir1_next = beat.write_data;
                    end else if (index_reg == REG_DATA1) begin
                        latch1_next = beat.write_data;
                    end
                end else if (device_reg == DEV_MODE) begin
                    if (index_reg == REG_MODE0) begin
                        mode0_next = beat.write_data;
                    end else if (index_reg == REG_MODE1) begin
                        mode1_next = beat.write_data;
                    end
                end
            end
        end else if (is_open) begin
            if (at_index) begin
                rd_data = index_reg;
            end else if (at_data) begin
                rd_data = reg_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg  <= ST_LOCKED;
            index_reg  <= 8'h00;
            device_reg <= 8'h00;
            enable_reg <= 8'h00;
            dir0_reg   <= 8'hFF;
            latch0_reg <= 8'h00;
            dir1_reg   <= 8'hFF;
            latch1_reg <= 8'h00;
            mode0_reg  <= 8'h00;
            mode1_reg  <= 8'h00;
        end else if (step_en) begin
            stage_reg  <= stage_next;
            index_reg  <= index_next;
            device_reg <= device_next;
            enable_reg <= enable_next;
            dir0_reg   <= dir0_next;
            latch0_reg <= latch0_next;
            dir1_reg   <= dir1_next;
            latch1_reg <= latch1_next;
            mode0_reg  <= mode0_next;
            mode1_reg  <= mode1_next;
        end
    end

    // Pin outputs reflect the state after this access.
    always_comb begin
        result.read_data     = rd_data;
        result.address_hit   = at_index || at_data;
        result.unlocked_flag = stage_next == ST_OPEN;
        result.bank0_drive_enable = enable_next[0]
            ? (~dir0_next & ~(mode0_next & latch0_next) & PinMask) : 8'h00;
        result.bank0_drive_level  = latch0_next & PinMask;
        result.bank1_drive_enable = enable_next[1]
            ? (~dir1_next & ~(mode1_next & latch1_next) & PinMask) : 8'h00;
        result.bank1_drive_level  = latch1_next & PinMask;
    end

endmodule
`default_nettype wire

// ===== src/superio_gpio_config_port.sv =====
// Top level of the Super-I/O style index/data configuration port with two GPIO banks.
`default_nettype none
// Each input beat on s_ is one I/O bus access (read or write at io_address) together
// with the sampled pin levels of both banks. Each accepted beat yields exactly one
// result beat on m_: the read byte, whether the access hit the index or data port,
// the unlock status and the pin drive enables and levels after the access.
// Two writes of 0x87 to the index port unlock the space, 0xAA locks it again.
// The index port sits at port_base and the data port at port_base + 1; the user must
// set port_base and the chip ID value through the cfg_ write port only while no beat
// is in flight; the block does not enforce it. A beat enters an input register, then
// the decode and register update run into the result register. Unless the receiver
// stalls, a new beat can be taken every cycle, so throughput is one beat per clock.
// When the receiver stalls, the result register holds its beat and the input
// register absorbs one more beat; after that s_ready drops until m_ready rises.
// Reset (synchronous, aresetn low) empties both registers, locks the space, selects
// no device, disables both banks, makes all pins inputs and clears the latches and
// drive modes. Configuration returns to port base 0x2E and chip ID 0x1061.
module superio_gpio_config_port #(
    parameter int PINS_PER_BANK = 8
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           cfg_wr_en,
    input  wire logic           cfg_index,
    input  wire logic [15:0]    cfg_wr_data,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire sgcp_pkg::in_beat_t s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output sgcp_pkg::out_beat_t m_data
);
    import sgcp_pkg::*;

    logic [15:0] port_base_reg;
    logic [15:0] chip_id_reg;

    logic      in_valid_reg, in_valid_next;
    in_beat_t  in_data_reg;
    logic      out_valid_reg, out_valid_next;
    out_beat_t out_data_reg;
    out_beat_t core_result;

    logic out_free;
    logic advance;
    logic accept;

    // The result register can take a beat when it is empty or being drained.
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign accept   = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= core_result;
        end
    end

    // The user must write configuration registers only while the pipeline is empty; the block does not enforce it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            port_base_reg <= 16'h002E;
            chip_id_reg   <= 16'h1061;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_PORT_BASE: port_base_reg <= cfg_wr_data;
                CFG_CHIP_ID:   chip_id_reg   <= cfg_wr_data;
                default:       port_base_reg <= port_base_reg;
            endcase
        end
    end

    sgcp_core #(
        .PINS_PER_BANK(PINS_PER_BANK)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .beat      (in_data_reg),
        .port_base (port_base_reg),
        .chip_id   (chip_id_reg),
        .result    (core_result)
    );

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule
`default_nettype wire

// ===== src/sgcp_checker.sv =====
// Port-level checker for the configuration port and its bind to the top level.
`default_nettype none
`include "superio_gpio_config_port_defines.svh"
module sgcp_checker (
    input wire logic           aclk,
    input wire logic           aresetn,
    input wire logic           s_ready,
    input wire logic           m_valid,
    input wire logic           m_ready,
    input wire sgcp_pkg::out_beat_t m_data
);
    import sgcp_pkg::*;

    logic miss_read_ok;
    logic locked_read_ok;

    assign miss_read_ok   = m_data.read_data == 8'hFF || m_data.read_data == 8'h00;
    assign locked_read_ok = m_data.read_data == 8'hFF || m_data.read_data == 8'h00;

    // A stalled result beat holds.
    `SGCP_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result beat changed while stalled")

    // Reset leaves no result beat pending and the input open.
    `SGCP_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_valid && s_ready, "block not empty after reset")

    // The input only stalls while a result beat is held back by the receiver.
    `SGCP_ASSERT_NOW(a_input_stall, aclk, aresetn, !s_ready, m_valid && !m_ready, "input stalled without a blocked result")

    // An access that hits neither port reads all ones, or zero for a write.
    `SGCP_ASSERT_NOW(a_miss_read, aclk, aresetn, m_valid && !m_data.address_hit, miss_read_ok, "missed access returned register data")

    // While locked no register contents are visible.
    `SGCP_ASSERT_NOW(a_locked_read, aclk, aresetn, m_valid && !m_data.unlocked_flag, locked_read_ok, "locked access returned register data")

endmodule

bind superio_gpio_config_port sgcp_checker u_sgcp_checker (.*);
`default_nettype wire
